/* design/gru_gate_update_top_macros.svh */
// ----------------------------------------------------------------------------
// GRU gate update assertion macros
// Shared concurrent assertion forms for the gate update block.
// ----------------------------------------------------------------------------
`ifndef GRU_GATE_UPDATE_TOP_MACROS_SVH
`define GRU_GATE_UPDATE_TOP_MACROS_SVH

// cond implies conseq, checked at every rising edge outside reset
`define GGU_ASSERT_IMPLY(name, clk, rst, cond, conseq) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("ggu: implication failed");

// cond must never hold outside reset
`define GGU_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ggu: forbidden condition seen");

`endif

/* design/ggu_pkg.sv */
// ----------------------------------------------------------------------------
// GRU gate update package
// Shared widths, constants, the item tag and the sigmoid table generator.
// ----------------------------------------------------------------------------
package ggu_pkg;

   localparam int DATA_W = 16;

   // 1.0 in Q1.15
   localparam logic [15:0] ONE_Q15 = 16'h8000;

   // control that travels alongside the datapath
   typedef struct packed {
      logic              valid;
      logic              active;
      logic signed [15:0] prev_hidden;
   } ggu_tag_type;

   // restoring divide, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sigmoid table point k, Q1.15; points past the end repeat the last one
   function automatic logic [15:0] sig_rom_point(input int k, input int addr_bits,
                                                 input int frac_bits);
      int                 step_exp;
      int                 kk;
      logic [63:0]        term;
      logic [63:0]        t2;
      logic [63:0]        ek;
      logic [63:0]        a;
      logic [63:0]        d;
      logic [63:0]        q;
      logic signed [63:0] sum;
      step_exp = 15 - frac_bits - addr_bits;
      sum      = 64'sd1 <<< 31;
      term     = 64'd1 << 31;
      t2       = '0;
      // e^(-step) in Q31, Taylor series
      for (int n = 1; n < 80; n++) begin
         if (term != 64'd0) begin
            if (step_exp >= 0) begin
               t2 = term << step_exp;
            end else begin
               t2 = (term + (64'd1 << (-step_exp - 1))) >> (-step_exp);
            end
            term = udiv64(t2 + 64'(n >> 1), 64'(n));
            if (n[0]) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      a  = $unsigned(sum);
      kk = (k > (1 << addr_bits)) ? (1 << addr_bits) : k;
      ek = 64'd1 << 31;
      for (int j = 1; j <= kk; j++) begin
         ek = (ek * a + (64'd1 << 30)) >> 31;
      end
      d = (64'd1 << 31) + ek;
      q = udiv64((64'd1 << 46) + (d >> 1), d);
      return q[15:0];
   endfunction

endpackage

/* design/ggu_sigmoid.sv */
// ----------------------------------------------------------------------------
// GGU sigmoid unit
// Two-stage interpolated table sigmoid: registered table read, then
// interpolation and sign fold into a registered Q1.15 result.
// ----------------------------------------------------------------------------
module ggu_sigmoid import ggu_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 8,
   parameter int FRAC_BITS       = 11
) (
   input  logic        clock,
   input  logic [15:0] mag,     // |x|, at most 2^15
   input  logic        neg,     // x < 0
   output logic [15:0] sig
);

   localparam int SEG_BITS = 15 - TABLE_ADDR_BITS;
   localparam int IDX_W    = TABLE_ADDR_BITS + 1;
   localparam int ROM_SIZE = (1 << TABLE_ADDR_BITS) + 2;

   logic [15:0]          rom_tbl [ROM_SIZE];

   genvar k;
   generate
      for (k = 0; k < ROM_SIZE; k++) begin : g_rom
         localparam logic [15:0] POINT = sig_rom_point(k, TABLE_ADDR_BITS, FRAC_BITS);
         assign rom_tbl[k] = POINT;
      end
   endgenerate

   logic [IDX_W-1:0]       idx_lo;
   logic [IDX_W-1:0]       idx_hi;
   logic [15:0]            lo_ff;
   logic [15:0]            hi_ff;
   logic [SEG_BITS-1:0]    frac_ff;
   logic                   neg_ff;
   logic [15:0]            diff;
   logic [15+SEG_BITS:0]   prod;
   logic [15+SEG_BITS:0]   prod_rnd;
   logic [15:0]            y;
   logic [15:0]            sig_in;
   logic [15:0]            sig_ff;

   assign idx_lo = mag[15:SEG_BITS];
   assign idx_hi = idx_lo + IDX_W'(1);

   always_ff @(posedge clock) begin
      lo_ff   <= rom_tbl[idx_lo];
      hi_ff   <= rom_tbl[idx_hi];
      frac_ff <= mag[SEG_BITS-1:0];
      neg_ff  <= neg;
   end

   // table is nondecreasing, so the segment slope is unsigned
   assign diff     = hi_ff - lo_ff;
   assign prod     = {{SEG_BITS{1'b0}}, diff} * {{16{1'b0}}, frac_ff};
   assign prod_rnd = prod + ((16 + SEG_BITS)'(1) << (SEG_BITS - 1));
   assign y        = lo_ff + prod_rnd[15+SEG_BITS:SEG_BITS];
   assign sig_in   = neg_ff ? (ONE_Q15 - y) : y;

   always_ff @(posedge clock) begin
      sig_ff <= sig_in;
   end

   assign sig = sig_ff;

endmodule

/* design/ggu_cand_arg.sv */
// ----------------------------------------------------------------------------
// GGU candidate argument
// Forms u = sat16(cand_input + rnd(r * cand_recur, 15)) and the saturated
// magnitude and sign of 2u for the tanh lookup. Two register stages.
// ----------------------------------------------------------------------------
module ggu_cand_arg import ggu_pkg::*; (
   input  logic               clock,
   input  logic [15:0]        r_gate,
   input  logic signed [15:0] cand_recur_term,
   input  logic signed [15:0] cand_input_term,
   output logic [15:0]        arg_mag,
   output logic               arg_neg
);

   localparam logic signed [18:0] U_MAX = 19'(32767);
   localparam logic signed [18:0] U_MIN = 19'(-32768);

   logic signed [32:0] prod_in;
   logic signed [32:0] prod_ff;
   logic signed [15:0] cin_ff;
   logic signed [32:0] prod_rnd;
   logic signed [17:0] recur_q;
   logic signed [18:0] u_sum;
   logic signed [15:0] u_sat;
   logic [15:0]        u_mag;
   logic [15:0]        mag_in;
   logic [15:0]        mag_ff;
   logic               neg_ff;

   assign prod_in = $signed({1'b0, r_gate}) * cand_recur_term;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      cin_ff  <= cand_input_term;
   end

   assign prod_rnd = prod_ff + 33'sd16384;
   assign recur_q  = prod_rnd[32:15];
   assign u_sum    = 19'(cin_ff) + 19'(recur_q);

   always_comb begin
      if (u_sum > U_MAX) begin
         u_sat = 16'sh7fff;
      end else if (u_sum < U_MIN) begin
         u_sat = 16'sh8000;
      end else begin
         u_sat = u_sum[15:0];
      end
   end

   // |2u| clamps at the table end
   assign u_mag  = u_sat[15] ? 16'(-u_sat) : 16'(u_sat);
   assign mag_in = (u_mag[15] || u_mag[14]) ? ONE_Q15 : {u_mag[14:0], 1'b0};

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= u_sat[15];
   end

   assign arg_mag = mag_ff;
   assign arg_neg = neg_ff;

endmodule

/* design/ggu_blend.sv */
// ----------------------------------------------------------------------------
// GGU blend
// h = sat16(rnd((1-z)*c*2^F + z*prev*2^15, 30)), with inactive items passing
// prev through. Product stage, then sum/round/saturate into the result register.
// ----------------------------------------------------------------------------
module ggu_blend import ggu_pkg::*; #(
   parameter int FRAC_BITS = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  ggu_tag_type        tag,
   input  logic [15:0]        z_gate,
   input  logic [15:0]        tanh_sig,
   output logic signed [15:0] next_hidden,
   output logic               strobe
);

   localparam int SUM_W = ((FRAC_BITS + 30 > 45) ? FRAC_BITS + 30 : 45) + 2;
   localparam int HS_W  = SUM_W - 30;
   localparam logic signed [HS_W-1:0] H_MAX = HS_W'(32767);
   localparam logic signed [HS_W-1:0] H_MIN = HS_W'(-32768);

   logic [15:0]             one_minus_z;
   logic signed [17:0]      c_wide;
   logic signed [16:0]      cand;
   logic signed [33:0]      p1_in;
   logic signed [32:0]      p2_in;
   logic signed [33:0]      p1_ff;
   logic signed [32:0]      p2_ff;
   ggu_tag_type             tag_ff;
   logic signed [SUM_W-1:0] sum;
   logic signed [HS_W-1:0]  h_q;
   logic signed [15:0]      h_sat;
   logic signed [15:0]      out_in;
   logic signed [15:0]      out_ff;
   logic                    strobe_ff;

   assign one_minus_z = ONE_Q15 - z_gate;
   // tanh = 2*sigmoid(2u) - 1
   assign c_wide      = $signed({1'b0, tanh_sig, 1'b0}) - 18'sd32768;
   assign cand        = c_wide[16:0];
   assign p1_in       = $signed({1'b0, one_minus_z}) * cand;
   assign p2_in       = $signed({1'b0, z_gate}) * tag.prev_hidden;

   always_ff @(posedge clock) begin
      p1_ff                 <= p1_in;
      p2_ff                 <= p2_in;
      tag_ff.active         <= tag.active;
      tag_ff.prev_hidden    <= tag.prev_hidden;
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag.valid;
      end
   end

   assign sum = (SUM_W'(p1_ff) <<< FRAC_BITS) + (SUM_W'(p2_ff) <<< 15)
              + (SUM_W'(1) <<< 29);
   assign h_q = sum[SUM_W-1:30];

   always_comb begin
      if (h_q > H_MAX) begin
         h_sat = 16'sh7fff;
      end else if (h_q < H_MIN) begin
         h_sat = 16'sh8000;
      end else begin
         h_sat = h_q[15:0];
      end
   end

   assign out_in = tag_ff.active ? h_sat : tag_ff.prev_hidden;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tag_ff.valid;
      end
   end

   assign next_hidden = out_ff;
   assign strobe      = strobe_ff;

endmodule

/* design/gru_gate_update_top.sv */
// ----------------------------------------------------------------------------
// GRU gate update, linear-before-reset form
// One hidden element per item: z = sigmoid(update), r = sigmoid(reset),
// c = tanh(r*recur + input), next = (1-z)*c + z*prev, Q4.11 saturated; an
// inactive item returns prev unchanged. The block takes one item every clock
// and returns each result in order, on rsp_next_hidden with rsp_strobe high
// for a single cycle. The receiver cannot stall, so nothing is held back:
// busy is high only during reset. The register stages of the pipeline are
// input capture, table read and interpolation for the z and r sigmoids, the
// r multiply, the tanh argument saturation, table read and interpolation for
// tanh, the blend multiplies, and the round/saturate result register.
// ----------------------------------------------------------------------------
`include "gru_gate_update_top_macros.svh"

module gru_gate_update_top import ggu_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 8,
   parameter int FRAC_BITS       = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_update_pre,
   input  logic signed [15:0] req_reset_pre,
   input  logic signed [15:0] req_cand_input_term,
   input  logic signed [15:0] req_cand_recur_term,
   input  logic signed [15:0] req_prev_hidden,
   input  logic               req_active,
   output logic signed [15:0] rsp_next_hidden,
   output logic               rsp_strobe
);

   localparam int TAG_STAGES  = 7;   // stages 0..6 ahead of the blend
   localparam int RSP_LATENCY = 9;

   // item acceptance
   logic               valid_in;

   // tag pipeline, stages 0..6
   logic               valid_ff  [TAG_STAGES];
   logic               active_ff [TAG_STAGES];
   logic signed [15:0] prev_ff   [TAG_STAGES];

   // stage 0 gate inputs
   logic signed [15:0] upd0_ff;
   logic signed [15:0] rst0_ff;

   // candidate terms, stages 0..2
   logic signed [15:0] cin_ff  [3];
   logic signed [15:0] crec_ff [3];

   // z carried from stage 3 to stage 6
   logic [15:0]        zq_ff [3:6];

   logic [15:0]        z_mag;
   logic [15:0]        r_mag;
   logic [15:0]        z_sig;
   logic [15:0]        r_sig;
   logic [15:0]        arg_mag;
   logic               arg_neg;
   logic [15:0]        tanh_sig;
   ggu_tag_type        blend_tag;

   // no stall path; only reset holds items off
   assign busy     = reset;
   assign valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAG_STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= valid_in;
         for (int i = 1; i < TAG_STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload pipeline, no reset
   always_ff @(posedge clock) begin
      active_ff[0] <= req_active;
      prev_ff[0]   <= req_prev_hidden;
      upd0_ff      <= req_update_pre;
      rst0_ff      <= req_reset_pre;
      cin_ff[0]    <= req_cand_input_term;
      crec_ff[0]   <= req_cand_recur_term;
      for (int i = 1; i < TAG_STAGES; i++) begin
         active_ff[i] <= active_ff[i-1];
         prev_ff[i]   <= prev_ff[i-1];
      end
      for (int i = 1; i < 3; i++) begin
         cin_ff[i]  <= cin_ff[i-1];
         crec_ff[i] <= crec_ff[i-1];
      end
      zq_ff[3] <= z_sig;
      for (int i = 4; i <= 6; i++) begin
         zq_ff[i] <= zq_ff[i-1];
      end
   end

   // gate magnitudes; -(-32768) lands on 2^15, the last table point
   assign z_mag = upd0_ff[15] ? 16'(-upd0_ff) : 16'(upd0_ff);
   assign r_mag = rst0_ff[15] ? 16'(-rst0_ff) : 16'(rst0_ff);

   // stages 1-2: z and r gates
   ggu_sigmoid #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .FRAC_BITS       (FRAC_BITS)
   ) u_sig_z (
      .clock (clock),
      .mag   (z_mag),
      .neg   (upd0_ff[15]),
      .sig   (z_sig)
   );

   ggu_sigmoid #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .FRAC_BITS       (FRAC_BITS)
   ) u_sig_r (
      .clock (clock),
      .mag   (r_mag),
      .neg   (rst0_ff[15]),
      .sig   (r_sig)
   );

   // stages 3-4: tanh argument
   ggu_cand_arg u_cand_arg (
      .clock           (clock),
      .r_gate          (r_sig),
      .cand_recur_term (crec_ff[2]),
      .cand_input_term (cin_ff[2]),
      .arg_mag         (arg_mag),
      .arg_neg         (arg_neg)
   );

   // stages 5-6: sigmoid(2u), folded to tanh in the blend
   ggu_sigmoid #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .FRAC_BITS       (FRAC_BITS)
   ) u_sig_c (
      .clock (clock),
      .mag   (arg_mag),
      .neg   (arg_neg),
      .sig   (tanh_sig)
   );

   assign blend_tag.valid       = valid_ff[TAG_STAGES-1];
   assign blend_tag.active      = active_ff[TAG_STAGES-1];
   assign blend_tag.prev_hidden = prev_ff[TAG_STAGES-1];

   // stages 7-8: blend and result register
   ggu_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock       (clock),
      .reset       (reset),
      .tag         (blend_tag),
      .z_gate      (zq_ff[6]),
      .tanh_sig    (tanh_sig),
      .next_hidden (rsp_next_hidden),
      .strobe      (rsp_strobe)
   );

   // every accepted item produces a result strobe
   `GGU_ASSERT_IMPLY(a_rsp_latency, clock, reset, valid_in, ##RSP_LATENCY rsp_strobe)
   // no result strobe without a matching accepted item
   `GGU_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_strobe, $past(valid_in, RSP_LATENCY))
   // inactive items return prev_hidden untouched
   `GGU_ASSERT_IMPLY(a_pass_through, clock, reset, valid_in && !req_active, ##RSP_LATENCY (rsp_next_hidden == $past(req_prev_hidden, RSP_LATENCY)))
   // gate values never exceed 1.0
   `GGU_ASSERT_NEVER(a_gate_range, clock, reset, valid_ff[2] && (z_sig > ONE_Q15 || r_sig > ONE_Q15))

endmodule

/* verif/gru_gate_update_checker.sv */
// ----------------------------------------------------------------------------
// GRU gate update result checker
// Watches the item and result channels, predicts each next hidden value from
// its own sigmoid table and fixed-point math, and compares results in order.
// ----------------------------------------------------------------------------
module gru_gate_update_checker #(
   parameter int TABLE_ADDR_BITS = 8,
   parameter int FRAC_BITS       = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_update_pre,
   input  logic signed [15:0] req_reset_pre,
   input  logic signed [15:0] req_cand_input_term,
   input  logic signed [15:0] req_cand_recur_term,
   input  logic signed [15:0] req_prev_hidden,
   input  logic               req_active,
   input  logic signed [15:0] rsp_next_hidden,
   input  logic               rsp_strobe,
   output int                 mismatches,
   output int                 pending
);

   localparam int     SEG_BITS  = 15 - TABLE_ADDR_BITS;
   localparam int     LAST_PT   = 1 << TABLE_ADDR_BITS;
   localparam longint UNITY_Q15 = 32768;

   longint             sigmoid_table [0:LAST_PT+1];
   logic signed [15:0] expected_hidden_q [$];
   int                 err_count = 0;
   int                 waiting   = 0;
   int                 rsp_index = 0;

   assign mismatches = err_count;
   assign pending    = waiting;

   // sampled sigmoid, Q1.15, over magnitudes 0 .. 2^15
   initial begin : build_sigmoid_table
      longint unsigned term;
      longint unsigned t2;
      longint unsigned ek;
      longint unsigned decay;
      longint unsigned denom;
      longint          sum;
      int              step_exp;
      step_exp = 15 - FRAC_BITS - TABLE_ADDR_BITS;
      sum      = 64'sd1 <<< 31;
      term     = 64'd1 << 31;
      // e^(-step) in Q31 from the alternating series
      for (int n = 1; n < 80 && term != 0; n++) begin
         if (step_exp >= 0) begin
            t2 = term << step_exp;
         end else begin
            t2 = (term + (64'd1 << (-step_exp - 1))) >> (-step_exp);
         end
         term = (t2 + 64'(n / 2)) / 64'(n);
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      decay = longint'(sum);
      ek    = 64'd1 << 31;
      for (int k = 0; k <= LAST_PT; k++) begin
         if (k > 0) begin
            ek = (ek * decay + (64'd1 << 30)) >> 31;
         end
         denom            = (64'd1 << 31) + ek;
         sigmoid_table[k] = longint'(((64'd1 << 46) + denom / 2) / denom);
      end
      sigmoid_table[LAST_PT+1] = sigmoid_table[LAST_PT];
   end

   function automatic longint saturate16(input longint v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // linear interpolation between table points, magnitude clipped at 2^15
   function automatic longint sigmoid_of_mag(input longint m);
      longint idx;
      longint frac;
      longint lo;
      longint hi;
      if (m > 32768) begin
         m = 32768;
      end
      idx  = m >> SEG_BITS;
      frac = m & ((64'sd1 <<< SEG_BITS) - 1);
      lo   = sigmoid_table[idx];
      hi   = sigmoid_table[idx + 1];
      return lo + (((hi - lo) * frac + (64'sd1 <<< (SEG_BITS - 1))) >>> SEG_BITS);
   endfunction

   function automatic longint sigmoid_q15(input longint x);
      if (x >= 0) begin
         return sigmoid_of_mag(x);
      end
      return UNITY_Q15 - sigmoid_of_mag(-x);
   endfunction

   function automatic logic signed [15:0] predict_next_hidden(
      input logic signed [15:0] upd,
      input logic signed [15:0] rst,
      input logic signed [15:0] cin,
      input logic signed [15:0] crec,
      input logic signed [15:0] prev,
      input logic               act
   );
      longint z;
      longint r;
      longint u;
      longint c;
      longint h;
      if (!act) begin
         return prev;
      end
      z = sigmoid_q15(longint'(upd));
      r = sigmoid_q15(longint'(rst));
      u = saturate16(longint'(cin) + ((r * longint'(crec) + 16384) >>> 15));
      // tanh(u) = 2*sigmoid(2u) - 1
      c = 2 * sigmoid_q15(2 * u) - UNITY_Q15;
      h = (UNITY_Q15 - z) * c * (64'sd1 <<< FRAC_BITS)
          + z * longint'(prev) * UNITY_Q15;
      h = saturate16((h + (64'sd1 <<< 29)) >>> 30);
      return 16'(h);
   endfunction

   always @(posedge clock) begin : watch
      logic signed [15:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_hidden_q.size() == 0) begin
            if (err_count < 10) begin
               $display("ERROR: result %0d arrived with no item outstanding, got %0d",
                        rsp_index, rsp_next_hidden);
            end
            err_count <= err_count + 1;
         end else begin
            want = expected_hidden_q.pop_front();
            if (rsp_next_hidden !== want) begin
               if (err_count < 10) begin
                  $display("ERROR: result %0d next_hidden expected %0d, got %0d",
                           rsp_index, want, rsp_next_hidden);
               end
               err_count <= err_count + 1;
            end
         end
         rsp_index++;
      end
      if (!reset && start && !busy) begin
         expected_hidden_q.push_back(predict_next_hidden(req_update_pre, req_reset_pre,
                                                         req_cand_input_term,
                                                         req_cand_recur_term,
                                                         req_prev_hidden, req_active));
      end
      waiting <= expected_hidden_q.size();
   end

endmodule

/* verif/gru_gate_update_top_tb.sv */
// ----------------------------------------------------------------------------
// GRU gate update testbench
// Drives directed corner items and then bursty random items into the gate
// update block; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module gru_gate_update_top_tb;

   localparam int TABLE_ADDR_BITS = 8;
   localparam int FRAC_BITS       = 11;
   localparam int RANDOM_ITEMS    = 1750;
   // pipeline depth is 9; a little margin for the drain at the end
   localparam int DRAIN_CYCLES    = 16;
   // idle cycles tolerated before the run is declared hung
   localparam int IDLE_LIMIT      = 2000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_update_pre;
   logic signed [15:0] req_reset_pre;
   logic signed [15:0] req_cand_input_term;
   logic signed [15:0] req_cand_recur_term;
   logic signed [15:0] req_prev_hidden;
   logic               req_active;
   logic signed [15:0] rsp_next_hidden;
   logic               rsp_strobe;
   int                 mismatches;
   int                 pending;
   int                 idle_cycles = 0;

   gru_gate_update_top #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .FRAC_BITS       (FRAC_BITS)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_update_pre      (req_update_pre),
      .req_reset_pre       (req_reset_pre),
      .req_cand_input_term (req_cand_input_term),
      .req_cand_recur_term (req_cand_recur_term),
      .req_prev_hidden     (req_prev_hidden),
      .req_active          (req_active),
      .rsp_next_hidden     (rsp_next_hidden),
      .rsp_strobe          (rsp_strobe)
   );

   gru_gate_update_checker #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .FRAC_BITS       (FRAC_BITS)
   ) hidden_check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_update_pre      (req_update_pre),
      .req_reset_pre       (req_reset_pre),
      .req_cand_input_term (req_cand_input_term),
      .req_cand_recur_term (req_cand_recur_term),
      .req_prev_hidden     (req_prev_hidden),
      .req_active          (req_active),
      .rsp_next_hidden     (rsp_next_hidden),
      .rsp_strobe          (rsp_strobe),
      .mismatches          (mismatches),
      .pending             (pending)
   );

   // 10 unit period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // progress means an item taken or a result returned on this edge
   always @(posedge clock) begin
      if ((start && !busy && !reset) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
      end
      $display("gru_gate_update_top verification failed");
      $finish;
   end

   // Present one item and hold it until the block takes it. start stays
   // high on return so back-to-back items need no extra assignment.
   task automatic send_item(input logic signed [15:0] upd,
                            input logic signed [15:0] rst,
                            input logic signed [15:0] cin,
                            input logic signed [15:0] crec,
                            input logic signed [15:0] prev,
                            input logic               act);
      start               <= 1'b1;
      req_update_pre      <= upd;
      req_reset_pre       <= rst;
      req_cand_input_term <= cin;
      req_cand_recur_term <= crec;
      req_prev_hidden     <= prev;
      req_active          <= act;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // Mix of full-range words, the steep part of the sigmoid, moderate
   // values and hand-picked extremes.
   function automatic logic signed [15:0] rand_field();
      logic signed [15:0] pick [5];
      pick = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1};
      case ($urandom_range(0, 5))
         0, 1: begin
            return 16'($urandom);
         end
         2, 3: begin
            return 16'(int'($urandom_range(0, 16383)) - 8192);
         end
         4: begin
            return 16'(int'($urandom_range(0, 32767)) - 16384);
         end
         default: begin
            return pick[$urandom_range(0, 4)];
         end
      endcase
   endfunction

   initial begin : stimulus
      int sent;
      int burst_len;
      int gap;
      bit drained_once;
      sent                = 0;
      drained_once        = 1'b0;
      reset               <= 1'b1;
      start               <= 1'b0;
      req_update_pre      <= '0;
      req_reset_pre       <= '0;
      req_cand_input_term <= '0;
      req_cand_recur_term <= '0;
      req_prev_hidden     <= '0;
      req_active          <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed corners ----
      // ended sequence: prev must pass straight through, whatever else is set
      send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
      send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_item(16'sh1234, -16'sd77, 16'sh0400, -16'sh0400, 16'sh5a5a, 1'b0);
      // all zero: z = r = 0.5, c = 0
      send_item(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
      // all at the top and all at the bottom of the range; the bottom one
      // hits magnitude 2^15, the last table point
      send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
      send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
      // z near 1: result follows prev
      send_item(16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 1'b1);
      send_item(16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 1'b1);
      // z near 0: result follows the candidate
      send_item(16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000, 16'sh8000, 1'b1);
      send_item(16'sh8000, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh7fff, 1'b1);
      // large input terms with large recurrent terms of either sign; like signs saturate the tanh argument
      send_item(16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000, 1'b1);
      send_item(16'sh0000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000, 1'b1);
      send_item(16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000, 1'b1);
      // r near 0 suppresses the recurrent term
      send_item(16'sh0000, 16'sh8000, 16'sh0200, 16'sh7fff, 16'sh0000, 1'b1);
      // small magnitudes around zero, half-LSB rounding territory
      send_item(16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, 1'b1);
      send_item(-16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b1);
      // exactly +-1.0 and +-4.0 in Q4.11
      send_item(16'sh0800, -16'sh0800, 16'sh0800, 16'sh0800, -16'sh0800, 1'b1);
      send_item(16'sh2000, -16'sh2000, -16'sh2000, 16'sh2000, 16'sh2000, 1'b1);
      // alternating bit patterns
      send_item(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 1'b1);
      send_item(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 1'b1);

      // ---- random bursts ----
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 48);
         for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
            send_item(rand_field(), rand_field(), rand_field(), rand_field(),
                      rand_field(), $urandom_range(0, 9) != 0);
            sent++;
         end
         if (!drained_once && sent >= RANDOM_ITEMS / 2) begin
            // hold off until the pipeline has fully emptied
            drained_once = 1'b1;
            start <= 1'b0;
            do begin
               @(posedge clock);
            end while (pending != 0);
         end else begin
            // a quarter of the bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      start <= 1'b0;

      // drain the pipeline, then leave room for anything stray
      do begin
         @(posedge clock);
      end while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending == 0) begin
         $display("gru_gate_update_top verification clean");
      end else begin
         $display("gru_gate_update_top verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/ggu_pkg.sv
design/ggu_sigmoid.sv
design/ggu_cand_arg.sv
design/ggu_blend.sv
design/gru_gate_update_top.sv
verif/gru_gate_update_checker.sv
verif/gru_gate_update_top_tb.sv
